// ----- hdl/pidsr_pkg.sv -----
// Shared types and constants of the PID stepper speed ramp block.
package pidsr_pkg;

   // Field widths
   localparam int OP_W       = 2;
   localparam int ERR_W      = 16;
   localparam int SPEED_W    = 20;
   localparam int GAIN_W     = 16;
   localparam int RATE_W     = 14;
   localparam int STEP_HZ_W  = 10;

   // Configuration port
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 20;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_P     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_I     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_GAIN_D     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MAX = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_OUTPUT_MIN = 3'd4;

   // Operation codes; bit 1 set selects direct speed
   localparam logic [OP_W-1:0] OP_PID        = 2'd0;
   localparam logic [OP_W-1:0] OP_PID_FF     = 2'd1;
   localparam logic [OP_W-1:0] OP_DIRECT     = 2'd2;
   localparam int              OP_DIRECT_BIT = 1;

   // Integral limit, +-10000 units in Q15.8
   localparam logic signed [23:0] INT_LIMIT = 24'sd2560000;

   // Speed limits and ramp steps in 1/16 Hz
   localparam logic [RATE_W-1:0] RATE_MIN_Q4    = 14'd256;
   localparam logic [RATE_W-1:0] RATE_MAX_Q4    = 14'd9600;
   localparam logic [RATE_W-1:0] RAMP_NORMAL_Q4 = 14'd1280;
   localparam logic [RATE_W-1:0] RAMP_FF_Q4     = 14'd640;
   localparam logic [RATE_W-1:0] STOP_BELOW_Q4  = 14'd16;

   // Command queue between controller and driver stage
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = 1;

   // Speed command handed from the controller to the driver stage
   typedef struct packed {
      logic signed [SPEED_W-1:0] target;
      logic                      slow_ramp;
   } pidsr_cmd_type;

endpackage

// ----- hdl/pidsr_if.sv -----
// Request and response channel interfaces of the PID stepper speed ramp block.
interface pidsr_req_if import pidsr_pkg::*; ();
   logic                      valid;
   logic                      ready;
   logic [OP_W-1:0]           op;
   logic signed [ERR_W-1:0]   track_error;
   logic signed [SPEED_W-1:0] feedforward;
   logic signed [SPEED_W-1:0] direct_speed;

   modport source (output valid, op, track_error, feedforward, direct_speed, input ready);
   modport sink   (input valid, op, track_error, feedforward, direct_speed, output ready);
endinterface

interface pidsr_rsp_if import pidsr_pkg::*; ();
   logic                 valid;
   logic                 ready;
   logic [STEP_HZ_W-1:0] step_rate_hz;
   logic                 driver_enable;
   logic                 direction;
   logic                 dir_changed;

   modport source (output valid, step_rate_hz, driver_enable, direction, dir_changed,
                   input ready);
   modport sink   (input valid, step_rate_hz, driver_enable, direction, dir_changed,
                   output ready);
endinterface

// ----- hdl/pid_stepper_speed_ramp_core.sv -----
// PID stepper speed ramp: a PID transaction steps the shared MAC through MAC0, MAC1, MAC2,
// then CLAMP and OUT, and no new request is taken before OUT; one direct speed transaction
// per cycle while the queue has room, going straight to OUT. The driver stage takes one
// command per cycle while no response waits on the receiver. A 2-entry command queue
// decouples the controller from the driver stage. Reset is synchronous, active high: gains,
// clamps, integral, previous error, ramp rate and direction clear to zero; no clearing pass.
module pid_stepper_speed_ramp_core import pidsr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pidsr_req_if.sink             req_ch,
   pidsr_rsp_if.source           rsp_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data
);

   pidsr_cmd_type front_cmd;
   logic          front_valid;
   logic          front_ready;
   pidsr_cmd_type back_cmd;
   logic          back_valid;
   logic          back_ready;

   // Controller front end
   pidsr_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .cmd         (front_cmd),
      .cmd_valid   (front_valid),
      .cmd_ready   (front_ready)
   );

   // Command queue
   pidsr_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .in_cmd    (front_cmd),
      .in_valid  (front_valid),
      .in_ready  (front_ready),
      .out_cmd   (back_cmd),
      .out_valid (back_valid),
      .out_ready (back_ready)
   );

   // Driver stage
   pidsr_drive u_drive (
      .clock     (clock),
      .reset     (reset),
      .cmd       (back_cmd),
      .cmd_valid (back_valid),
      .cmd_ready (back_ready),
      .rsp_ch    (rsp_ch)
   );

endmodule

// ----- hdl/pidsr_front.sv -----
// Front end: accepts requests, holds the gains, runs the PID step, issues speed commands.
module pidsr_front import pidsr_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pidsr_req_if.sink             req_ch,
   input  logic                  csr_wr_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wr_data,
   output pidsr_cmd_type         cmd,
   output logic                  cmd_valid,
   input  logic                  cmd_ready
);

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC0  = 3'd1;
   localparam logic [2:0] ST_MAC1  = 3'd2;
   localparam logic [2:0] ST_MAC2  = 3'd3;
   localparam logic [2:0] ST_CLAMP = 3'd4;
   localparam logic [2:0] ST_OUT   = 3'd5;

   // Clamp against output_max first, then output_min
   function automatic logic signed [SPEED_W-1:0] clamp_out(
      input logic signed [28:0]        v,
      input logic signed [SPEED_W-1:0] hi,
      input logic signed [SPEED_W-1:0] lo
   );
      logic signed [28:0] r;
      logic signed [28:0] hi_x;
      logic signed [28:0] lo_x;
      hi_x = hi;
      lo_x = lo;
      r = v;
      if (r > hi_x) r = hi_x;
      if (r < lo_x) r = lo_x;
      return r[SPEED_W-1:0];
   endfunction

   logic [2:0]                state_ff, state_in;
   logic signed [GAIN_W-1:0]  gain_p_ff, gain_p_in;
   logic signed [GAIN_W-1:0]  gain_i_ff, gain_i_in;
   logic signed [GAIN_W-1:0]  gain_d_ff, gain_d_in;
   logic signed [SPEED_W-1:0] out_max_ff, out_max_in;
   logic signed [SPEED_W-1:0] out_min_ff, out_min_in;
   logic signed [22:0]        integral_ff, integral_in;
   logic signed [ERR_W-1:0]   prev_err_ff, prev_err_in;
   logic signed [ERR_W-1:0]   err_ff, err_in;
   logic signed [ERR_W:0]     diff_ff, diff_in;
   logic signed [40:0]        acc_ff, acc_in;
   logic signed [SPEED_W-1:0] pid_ff, pid_in;
   logic signed [SPEED_W-1:0] ff_val_ff, ff_val_in;
   logic                      is_ff_ff, is_ff_in;

   logic                      push;
   logic                      req_take;
   logic signed [23:0]        int_sum;
   logic signed [23:0]        int_old_x;
   logic signed [23:0]        err_new_x;
   logic signed [ERR_W:0]     err_new_d;
   logic signed [ERR_W:0]     prev_d;
   logic signed [GAIN_W-1:0]  mul_gain;
   logic signed [22:0]        mul_oper;
   logic signed [22:0]        err_x23;
   logic signed [22:0]        diff_x23;
   logic signed [38:0]        product;
   logic signed [40:0]        product_x;
   logic signed [28:0]        ff_sum;
   logic signed [28:0]        pid_x;
   logic signed [28:0]        ffv_x;

   // Handshakes
   assign push         = (state_ff == ST_OUT) && cmd_ready;
   assign cmd_valid    = (state_ff == ST_OUT);
   assign req_ch.ready = (state_ff == ST_IDLE) || push;
   assign req_take     = req_ch.valid && req_ch.ready;

   // Integral update and error difference for a new request
   always_comb begin
      int_old_x = integral_ff;
      err_new_x = req_ch.track_error;
      int_sum   = int_old_x + err_new_x;
      err_new_d = req_ch.track_error;
      prev_d    = prev_err_ff;
   end

   // Shared multiplier, one partial product per MAC cycle
   always_comb begin
      err_x23  = err_ff;
      diff_x23 = diff_ff;
      case (state_ff)
         ST_MAC1: begin
            mul_gain = gain_i_ff;
            mul_oper = integral_ff;
         end
         ST_MAC2: begin
            mul_gain = gain_d_ff;
            mul_oper = diff_x23;
         end
         default: begin
            mul_gain = gain_p_ff;
            mul_oper = err_x23;
         end
      endcase
      product   = mul_gain * mul_oper;
      product_x = product;
   end

   // Feedforward sum and outgoing command
   always_comb begin
      pid_x      = pid_ff;
      ffv_x      = ff_val_ff;
      ff_sum     = pid_x + ffv_x;
      cmd.target = is_ff_ff ? clamp_out(ff_sum, out_max_ff, out_min_ff) : pid_ff;
      cmd.slow_ramp = is_ff_ff;
   end

   // Next state of the sequencer and datapath registers
   always_comb begin
      state_in    = state_ff;
      integral_in = integral_ff;
      prev_err_in = prev_err_ff;
      err_in      = err_ff;
      diff_in     = diff_ff;
      acc_in      = acc_ff;
      pid_in      = pid_ff;
      ff_val_in   = ff_val_ff;
      is_ff_in    = is_ff_ff;

      case (state_ff)
         ST_IDLE: begin
            state_in = ST_IDLE;
         end
         ST_MAC0: begin
            acc_in   = product_x;
            state_in = ST_MAC1;
         end
         ST_MAC1: begin
            acc_in   = acc_ff + product_x;
            state_in = ST_MAC2;
         end
         ST_MAC2: begin
            acc_in   = acc_ff + product_x;
            state_in = ST_CLAMP;
         end
         ST_CLAMP: begin
            // floor division by 4096 is an arithmetic shift
            pid_in   = clamp_out(acc_ff[40:12], out_max_ff, out_min_ff);
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (push) state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (req_take) begin
         if (req_ch.op[OP_DIRECT_BIT]) begin
            pid_in   = req_ch.direct_speed;
            is_ff_in = 1'b0;
            state_in = ST_OUT;
         end else begin
            if (int_sum > INT_LIMIT) begin
               integral_in = INT_LIMIT[22:0];
            end else if (int_sum < -INT_LIMIT) begin
               integral_in = 23'(-INT_LIMIT);
            end else begin
               integral_in = int_sum[22:0];
            end
            diff_in     = err_new_d - prev_d;
            prev_err_in = req_ch.track_error;
            err_in      = req_ch.track_error;
            ff_val_in   = req_ch.feedforward;
            is_ff_in    = (req_ch.op == OP_PID_FF);
            state_in    = ST_MAC0;
         end
      end
   end

   // Configuration writes
   always_comb begin
      gain_p_in  = gain_p_ff;
      gain_i_in  = gain_i_ff;
      gain_d_in  = gain_d_ff;
      out_max_in = out_max_ff;
      out_min_in = out_min_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_GAIN_P:     gain_p_in  = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_I:     gain_i_in  = csr_wr_data[GAIN_W-1:0];
            CSR_GAIN_D:     gain_d_in  = csr_wr_data[GAIN_W-1:0];
            CSR_OUTPUT_MAX: out_max_in = csr_wr_data[SPEED_W-1:0];
            CSR_OUTPUT_MIN: out_min_in = csr_wr_data[SPEED_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         gain_p_ff   <= '0;
         gain_i_ff   <= '0;
         gain_d_ff   <= '0;
         out_max_ff  <= '0;
         out_min_ff  <= '0;
         integral_ff <= '0;
         prev_err_ff <= '0;
      end else begin
         state_ff    <= state_in;
         gain_p_ff   <= gain_p_in;
         gain_i_ff   <= gain_i_in;
         gain_d_ff   <= gain_d_in;
         out_max_ff  <= out_max_in;
         out_min_ff  <= out_min_in;
         integral_ff <= integral_in;
         prev_err_ff <= prev_err_in;
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      err_ff    <= err_in;
      diff_ff   <= diff_in;
      acc_ff    <= acc_in;
      pid_ff    <= pid_in;
      ff_val_ff <= ff_val_in;
      is_ff_ff  <= is_ff_in;
   end

endmodule

// ----- hdl/pidsr_queue.sv -----
// Short command queue between the controller front end and the driver stage.
module pidsr_queue import pidsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  pidsr_cmd_type in_cmd,
   input  logic          in_valid,
   output logic          in_ready,
   output pidsr_cmd_type out_cmd,
   output logic          out_valid,
   input  logic          out_ready
);

   pidsr_cmd_type            entries_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_PTR_W:0]     count_ff, count_in;
   logic                     push;
   logic                     pop;

   assign in_ready  = (count_ff != (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_cmd   = entries_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   // Pointer and fill count update
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) count_in = count_ff + 1'b1;
      if (pop && !push) count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Entry storage
   always_ff @(posedge clock) begin
      if (push) entries_ff[wr_ptr_ff] <= in_cmd;
   end

endmodule

// ----- hdl/pidsr_drive.sv -----
// Driver stage: stop detect, speed clamp, direction change and slew ramp, response register.
module pidsr_drive import pidsr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  pidsr_cmd_type cmd,
   input  logic          cmd_valid,
   output logic          cmd_ready,
   pidsr_rsp_if.source   rsp_ch
);

   logic [RATE_W-1:0]    rate_ff, rate_in;
   logic                 dir_ff, dir_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [STEP_HZ_W-1:0] step_ff, step_in;
   logic                 enable_ff, enable_in;
   logic                 out_dir_ff, out_dir_in;
   logic                 changed_ff, changed_in;

   logic                 pop;
   logic                 neg;
   logic [SPEED_W-1:0]   t_u;
   logic [SPEED_W-1:0]   mag;
   logic                 stop;
   logic [RATE_W-1:0]    mag_c;
   logic                 flip;
   logic [RATE_W-1:0]    base;
   logic [RATE_W:0]      ramp;
   logic [RATE_W:0]      up;
   logic [RATE_W:0]      mag_up;
   logic [RATE_W:0]      nxt;
   logic [RATE_W-1:0]    cur;

   assign cmd_ready     = !rsp_valid_ff || rsp_ch.ready;
   assign pop           = cmd_valid && cmd_ready;
   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.step_rate_hz  = step_ff;
   assign rsp_ch.driver_enable = enable_ff;
   assign rsp_ch.direction     = out_dir_ff;
   assign rsp_ch.dir_changed   = changed_ff;

   // Magnitude, stop test and speed clamp
   always_comb begin
      t_u  = cmd.target;
      neg  = cmd.target[SPEED_W-1];
      mag  = neg ? (~t_u + 1'b1) : t_u;
      stop = (mag < SPEED_W'(STOP_BELOW_Q4));
      if (mag < SPEED_W'(RATE_MIN_Q4)) begin
         mag_c = RATE_MIN_Q4;
      end else if (mag > SPEED_W'(RATE_MAX_Q4)) begin
         mag_c = RATE_MAX_Q4;
      end else begin
         mag_c = mag[RATE_W-1:0];
      end
   end

   // Slew ramp from the running rate, restarted at zero on a direction flip
   always_comb begin
      flip   = (neg != dir_ff);
      base   = flip ? '0 : rate_ff;
      ramp   = cmd.slow_ramp ? (RATE_W+1)'(RAMP_FF_Q4) : (RATE_W+1)'(RAMP_NORMAL_Q4);
      up     = {1'b0, base} + ramp;
      mag_up = {1'b0, mag_c} + ramp;
      if ({1'b0, mag_c} > up) begin
         nxt = up;
      end else if (mag_up < {1'b0, base}) begin
         nxt = {1'b0, base} - ramp;
      end else begin
         nxt = {1'b0, mag_c};
      end
      if (nxt < (RATE_W+1)'(RATE_MIN_Q4)) begin
         cur = RATE_MIN_Q4;
      end else if (nxt > (RATE_W+1)'(RATE_MAX_Q4)) begin
         cur = RATE_MAX_Q4;
      end else begin
         cur = nxt[RATE_W-1:0];
      end
   end

   // Next values of ramp state and response register
   always_comb begin
      rate_in      = rate_ff;
      dir_in       = dir_ff;
      step_in      = step_ff;
      enable_in    = enable_ff;
      out_dir_in   = out_dir_ff;
      changed_in   = changed_ff;
      rsp_valid_in = rsp_ch.ready ? 1'b0 : rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
         if (stop) begin
            rate_in    = '0;
            step_in    = '0;
            enable_in  = 1'b0;
            out_dir_in = dir_ff;
            changed_in = 1'b0;
         end else begin
            rate_in    = cur;
            dir_in     = neg;
            step_in    = cur[RATE_W-1:4];
            enable_in  = 1'b1;
            out_dir_in = neg;
            changed_in = flip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_ff      <= '0;
         dir_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rate_ff      <= rate_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      step_ff    <= step_in;
      enable_ff  <= enable_in;
      out_dir_ff <= out_dir_in;
      changed_ff <= changed_in;
   end

endmodule

// ----- dv/pid_stepper_speed_ramp_core_tb.sv -----
// Self-checking testbench of the PID stepper speed ramp core, with a built-in speed predictor.
module pid_stepper_speed_ramp_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import pidsr_pkg::*;

   localparam int     CLK_HALF      = 4;
   localparam int     RESET_CYCLES  = 11;
   localparam int     MAX_IDLE      = 17;
   localparam int     DRAIN_LIMIT   = 4000;
   localparam int     SETTLE_CYCLES = 12;
   localparam int     REPORT_LIMIT  = 10;
   localparam longint RUN_LIMIT_NS  = 5_000_000;
   localparam int     HOLD_CYCLES   = 60;
   localparam int     RAND_PHASES   = 6;
   localparam int     PHASE_ITEMS   = 140;
   localparam int     PID_SHIFT     = 12;

   // op 3 is not defined by the block; it decodes as direct speed
   localparam logic [OP_W-1:0] OP_SPARE = 2'd3;

   // random burst shapes
   localparam int BURST_WINDUP = 0;
   localparam int BURST_DIRECT = 1;
   localparam int BURST_MIXED  = 2;
   localparam int BURST_TRACK  = 3;

   // rate limits as plain signed numbers
   localparam longint MIN_RATE     = RATE_MIN_Q4;
   localparam longint MAX_RATE     = RATE_MAX_Q4;
   localparam longint STOP_RATE    = STOP_BELOW_Q4;
   localparam longint STEP_NORMAL  = RAMP_NORMAL_Q4;
   localparam longint STEP_FF      = RAMP_FF_Q4;
   localparam longint INTEGRAL_MAX = INT_LIMIT;

   typedef struct packed {
      logic [OP_W-1:0]           op;
      logic signed [ERR_W-1:0]   track_error;
      logic signed [SPEED_W-1:0] feedforward;
      logic signed [SPEED_W-1:0] direct_speed;
   } speed_req_type;

   typedef struct packed {
      logic [STEP_HZ_W-1:0] step_rate_hz;
      logic                 driver_enable;
      logic                 direction;
      logic                 dir_changed;
   } speed_rsp_type;

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  csr_wr_en;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wr_data;

   pidsr_req_if req_ch ();
   pidsr_rsp_if rsp_ch ();

   pid_stepper_speed_ramp_core dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   // predictor copy of the registers and state
   logic signed [GAIN_W-1:0]  kp = '0, ki = '0, kd = '0;
   logic signed [SPEED_W-1:0] out_hi = '0, out_lo = '0;
   logic signed [22:0]        integral_q = '0;
   logic signed [ERR_W-1:0]   prior_track_err = '0;
   logic [RATE_W-1:0]         ramp_rate = '0;
   logic                      motor_dir = 1'b0;

   speed_rsp_type pending_speed_q[$];

   bit source_idle = 1'b0;
   bit sink_idle   = 1'b0;
   int sink_hold_cycles = 0;

   int mismatch_count = 0;
   int checked_count  = 0;
   int n_pid = 0, n_ff = 0, n_direct = 0, n_settings = 0;
   int n_stops = 0, n_flips = 0, n_windup = 0;

   // clock
   always begin
      #(CLK_HALF) clock = 1'b1;
      #(CLK_HALF) clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic longint clamp_to_output(longint v);
      if (v > longint'(out_hi)) v = out_hi;
      if (v < longint'(out_lo)) v = out_lo;
      return v;
   endfunction

   // integral windup clamp, PID sum in Q.16, floor to Q.4, output clamp
   function automatic longint pid_update(longint e);
      longint s;
      longint acc;
      s = longint'(integral_q) + e;
      if (s > INTEGRAL_MAX) begin
         s = INTEGRAL_MAX;
         n_windup++;
      end
      if (s < -INTEGRAL_MAX) begin
         s = -INTEGRAL_MAX;
         n_windup++;
      end
      integral_q = 23'(s);
      acc = longint'(kp) * e + longint'(ki) * s
          + longint'(kd) * (e - longint'(prior_track_err));
      prior_track_err = ERR_W'(e);
      return clamp_to_output(acc >>> PID_SHIFT);
   endfunction

   // stop / clamp / direction flip / slew ramp of the driver stage
   function automatic speed_rsp_type drive_motor(longint target, longint step);
      speed_rsp_type r;
      longint        mag;
      longint        cur;
      logic          want_dir;
      r = '0;
      mag = (target < 0) ? -target : target;
      want_dir = (target < 0);
      if (mag < STOP_RATE) begin
         ramp_rate = '0;
         r.direction = motor_dir;
         n_stops++;
         return r;
      end
      if (mag < MIN_RATE) mag = MIN_RATE;
      if (mag > MAX_RATE) mag = MAX_RATE;
      if (want_dir != motor_dir) begin
         ramp_rate = '0;
         motor_dir = want_dir;
         r.dir_changed = 1'b1;
         n_flips++;
      end
      cur = ramp_rate;
      if (mag > cur + step) cur = cur + step;
      else if (mag + step < cur) cur = cur - step;
      else cur = mag;
      if (cur < MIN_RATE) cur = MIN_RATE;
      if (cur > MAX_RATE) cur = MAX_RATE;
      ramp_rate = RATE_W'(cur);
      r.step_rate_hz = STEP_HZ_W'(cur >> 4);
      r.driver_enable = 1'b1;
      r.direction = motor_dir;
      return r;
   endfunction

   function automatic speed_rsp_type predict_step_rate(speed_req_type it);
      longint e;
      longint t;
      e = longint'($signed(it.track_error));
      if (it.op[OP_DIRECT_BIT]) begin
         n_direct++;
         return drive_motor(longint'($signed(it.direct_speed)), STEP_NORMAL);
      end else if (it.op == OP_PID_FF) begin
         n_ff++;
         t = clamp_to_output(pid_update(e) + longint'($signed(it.feedforward)));
         return drive_motor(t, STEP_FF);
      end else begin
         n_pid++;
         return drive_motor(pid_update(e), STEP_NORMAL);
      end
   endfunction

   // ---------------------------------------------------------------- drivers

   // one request transaction; entered and left just after a falling edge
   task automatic send_cmd(input logic [OP_W-1:0] op, input logic signed [ERR_W-1:0] e,
                           input logic signed [SPEED_W-1:0] ff,
                           input logic signed [SPEED_W-1:0] ds);
      speed_req_type it;
      int            gap;
      it = '{op, e, ff, ds};
      gap = source_idle ? $urandom_range(0, MAX_IDLE) : 0;
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_ch.op           <= it.op;
      req_ch.track_error  <= it.track_error;
      req_ch.feedforward  <= it.feedforward;
      req_ch.direct_speed <= it.direct_speed;
      req_ch.valid        <= 1'b1;
      do @(posedge clock); while (!req_ch.ready);
      pending_speed_q.push_back(predict_step_rate(it));
      @(negedge clock);
   endtask

   // let all outstanding responses come back, then settle
   task automatic wait_for_responses();
      int n;
      n = 0;
      req_ch.valid <= 1'b0;
      while (pending_speed_q.size() > 0 && n < DRAIN_LIMIT) begin
         @(negedge clock);
         n++;
      end
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // writes all five registers back to back; block must be idle
   task automatic write_settings(input logic signed [GAIN_W-1:0] p,
                                 input logic signed [GAIN_W-1:0] i,
                                 input logic signed [GAIN_W-1:0] d,
                                 input logic signed [SPEED_W-1:0] hi,
                                 input logic signed [SPEED_W-1:0] lo);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_GAIN_P;     csr_wr_data <= CSR_DATA_W'(p);  @(negedge clock);
      csr_index <= CSR_GAIN_I;     csr_wr_data <= CSR_DATA_W'(i);  @(negedge clock);
      csr_index <= CSR_GAIN_D;     csr_wr_data <= CSR_DATA_W'(d);  @(negedge clock);
      csr_index <= CSR_OUTPUT_MAX; csr_wr_data <= CSR_DATA_W'(hi); @(negedge clock);
      csr_index <= CSR_OUTPUT_MIN; csr_wr_data <= CSR_DATA_W'(lo); @(negedge clock);
      csr_wr_en <= 1'b0;
      kp = p;
      ki = i;
      kd = d;
      out_hi = hi;
      out_lo = lo;
      n_settings++;
   endtask

   // ---------------------------------------------------------------- random values

   function automatic logic signed [ERR_W-1:0] pick_error();
      int v;
      case ($urandom_range(0, 9))
         0: return ERR_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: begin
            v = $urandom_range(0, 2048);
            return ERR_W'(v - 1024);
         end
      endcase
   endfunction

   function automatic logic signed [SPEED_W-1:0] pick_speed();
      int v;
      case ($urandom_range(0, 9))
         0, 1: return SPEED_W'($urandom);
         2: begin
            v = $urandom_range(0, 40);
            return SPEED_W'(v - 20);
         end
         default: begin
            v = $urandom_range(0, 20000);
            return SPEED_W'(v - 10000);
         end
      endcase
   endfunction

   function automatic logic signed [GAIN_W-1:0] pick_gain();
      int v;
      case ($urandom_range(0, 4))
         0: return GAIN_W'($urandom);
         1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
         default: begin
            v = $urandom_range(0, 1024);
            return GAIN_W'(v - 512);
         end
      endcase
   endfunction

   // clamp bound: mostly inside the motor range, sometimes extreme or arbitrary
   function automatic logic signed [SPEED_W-1:0] pick_bound(bit upper);
      int v;
      case ($urandom_range(0, 9))
         0: return upper ? 20'sh7ffff : 20'sh80000;
         1: return SPEED_W'($urandom);
         default: begin
            v = $urandom_range(0, 12000);
            return upper ? SPEED_W'(v) : SPEED_W'(-v);
         end
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   // direct speed path under reset settings: stops, clamps, ramps, flips, spare op
   task automatic test_direct_speed();
      send_cmd(OP_DIRECT, '0, '0, 0);
      send_cmd(OP_DIRECT, '0, '0, 15);
      send_cmd(OP_DIRECT, '0, '0, -15);
      send_cmd(OP_DIRECT, '0, '0, 16);
      send_cmd(OP_DIRECT, '0, '0, 255);
      send_cmd(OP_DIRECT, 16'sh7fff, 20'sh7ffff, 524287);
      send_cmd(OP_DIRECT, '0, '0, 524287);
      send_cmd(OP_DIRECT, '0, '0, 524287);
      send_cmd(OP_DIRECT, '0, '0, 9600);
      send_cmd(OP_SPARE, 16'sh8000, 20'sh80000, -524288);
      send_cmd(OP_SPARE, '0, '0, -300);
      send_cmd(OP_DIRECT, '0, '0, -1);
      send_cmd(OP_DIRECT, '0, '0, 5000);
      // zero gains: PID gives a zero target, hence a stop
      send_cmd(OP_PID, 16'sh7fff, '0, '0);
      wait_for_responses();
   endtask

   // PID and feedforward with full-range clamps and field extremes
   task automatic test_pid_paths();
      write_settings(16'sd256, 16'sd16, 16'sd512, 20'sh7ffff, 20'sh80000);
      send_cmd(OP_PID, 16'sh7fff, '0, '0);
      send_cmd(OP_PID, 16'sh7fff, '0, '0);
      send_cmd(OP_PID, 16'sh8000, '0, '0);
      send_cmd(OP_PID, '0, '0, '0);
      send_cmd(OP_PID_FF, '0, 20'sh7ffff, '0);
      send_cmd(OP_PID_FF, 16'sd1, 20'sh80000, '0);
      send_cmd(OP_PID_FF, -16'sd1, 20'sd1000, '0);
      send_cmd(OP_PID, 16'sd256, '0, 20'sh7ffff);
      wait_for_responses();
   endtask

   // min bound above max bound: the min clamp wins
   task automatic test_crossed_clamp();
      write_settings(16'sd256, '0, '0, -20'sd5000, 20'sd3000);
      send_cmd(OP_PID, '0, '0, '0);
      send_cmd(OP_PID_FF, 16'sh8000, 20'sh80000, '0);
      send_cmd(OP_PID, 16'sh7fff, '0, '0);
      wait_for_responses();
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_backpressure();
      source_idle = 1'b0;
      sink_idle   = 1'b0;
      sink_hold_cycles = HOLD_CYCLES;
      for (int k = 0; k < 20; k++)
         send_cmd(OP_DIRECT, '0, '0, SPEED_W'(int'($urandom_range(300, 9000))));
      for (int k = 0; k < 4; k++)
         send_cmd(OP_PID, pick_error(), '0, '0);
      wait_for_responses();
   endtask

   // phases of random settings, each a string of shaped bursts
   task automatic test_random_traffic();
      int sent;
      int kind;
      int burst_len;
      int sign;
      logic [OP_W-1:0] op_keep;
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         wait_for_responses();
         case (ph)
            0: write_settings(16'sh7fff, 16'sh8000, 16'sh7fff, 20'sh7ffff, 20'sh80000);
            1: write_settings(16'sh8000, 16'sh7fff, 16'sh8000, 20'sd9600, -20'sd9600);
            default: write_settings(pick_gain(), pick_gain(), pick_gain(),
                                    pick_bound(1'b1), pick_bound(1'b0));
         endcase
         sent = 0;
         while (sent < PHASE_ITEMS) begin
            kind = (sent == 0 && ph % 2 == 0) ? BURST_WINDUP : $urandom_range(0, 3);
            sign = $urandom_range(0, 1) ? 1 : -1;
            op_keep = OP_W'($urandom_range(0, 1));
            source_idle = ($urandom_range(0, 3) != 0);
            sink_idle   = ($urandom_range(0, 3) != 0);
            burst_len = (kind == BURST_WINDUP) ? $urandom_range(80, 120)
                                               : $urandom_range(5, 30);
            for (int k = 0; k < burst_len; k++) begin
               case (kind)
                  // long same-sign error run drives the integral into its limit
                  BURST_WINDUP:
                     send_cmd(OP_W'($urandom_range(0, 1)),
                              ERR_W'(sign * int'($urandom_range(16384, 32767))),
                              pick_speed(), pick_speed());
                  // same-sign speed run exercises the ramp, with a little noise
                  BURST_DIRECT:
                     if ($urandom_range(0, 7) == 0)
                        send_cmd(OP_W'($urandom_range(0, 3)), pick_error(), pick_speed(),
                                 pick_speed());
                     else
                        send_cmd(($urandom_range(0, 3) == 0) ? OP_SPARE : OP_DIRECT,
                                 pick_error(), pick_speed(),
                                 SPEED_W'(sign * int'($urandom_range(0, 10000))));
                  BURST_MIXED:
                     send_cmd(OP_W'($urandom_range(0, 3)), pick_error(), pick_speed(),
                              pick_speed());
                  default:
                     send_cmd(op_keep, pick_error(),
                              SPEED_W'(sign * int'($urandom_range(0, 10000))), pick_speed());
               endcase
               sent++;
            end
         end
      end
      wait_for_responses();
   endtask

   // ---------------------------------------------------------------- response side

   // receiver: random stall after each response, plus an optional long hold
   initial begin : rsp_sink
      int stall;
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      rsp_ch.ready <= 1'b1;
      forever begin
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready));
         @(negedge clock);
         stall = sink_idle ? $urandom_range(0, MAX_IDLE) : 0;
         if (stall > 0 || sink_hold_cycles > 0) begin
            rsp_ch.ready <= 1'b0;
            while (stall > 0 || sink_hold_cycles > 0) begin
               if (sink_hold_cycles > 0) sink_hold_cycles--;
               else stall--;
               @(negedge clock);
            end
            rsp_ch.ready <= 1'b1;
         end
      end
   end

   // compare each response transaction with the oldest prediction
   always @(posedge clock) begin : rsp_check
      speed_rsp_type seen;
      speed_rsp_type want;
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         seen.step_rate_hz  = rsp_ch.step_rate_hz;
         seen.driver_enable = rsp_ch.driver_enable;
         seen.direction     = rsp_ch.direction;
         seen.dir_changed   = rsp_ch.dir_changed;
         if (pending_speed_q.size() == 0) begin
            if (mismatch_count < REPORT_LIMIT)
               $display("%0t: response with nothing pending: rate %0d en %b dir %b chg %b",
                        $realtime, seen.step_rate_hz, seen.driver_enable, seen.direction,
                        seen.dir_changed);
            mismatch_count++;
         end else begin
            want = pending_speed_q.pop_front();
            checked_count++;
            if (seen.step_rate_hz !== want.step_rate_hz ||
                seen.driver_enable !== want.driver_enable ||
                seen.direction !== want.direction ||
                seen.dir_changed !== want.dir_changed) begin
               if (mismatch_count < REPORT_LIMIT)
                  $display({"%0t: response %0d: expected rate %0d en %b dir %b chg %b,",
                            " got rate %0d en %b dir %b chg %b"},
                           $realtime, checked_count, want.step_rate_hz, want.driver_enable,
                           want.direction, want.dir_changed, seen.step_rate_hz,
                           seen.driver_enable, seen.direction, seen.dir_changed);
               mismatch_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------- sequence

   initial begin : main
      reset              = 1'b1;
      csr_wr_en          = 1'b0;
      csr_index          = '0;
      csr_wr_data        = '0;
      req_ch.valid       = 1'b0;
      req_ch.op          = '0;
      req_ch.track_error = '0;
      req_ch.feedforward = '0;
      req_ch.direct_speed = '0;
      repeat (RESET_CYCLES) @(negedge clock);
      reset <= 1'b0;

      test_direct_speed();
      test_pid_paths();
      test_crossed_clamp();
      test_backpressure();
      test_random_traffic();

      // predictions that never got a response
      mismatch_count += pending_speed_q.size();

      $display("Checked %0d responses: %0d PID, %0d feedforward, %0d direct, %0d settings.",
               checked_count, n_pid, n_ff, n_direct, n_settings);
      $display("Seen %0d stops, %0d direction changes, %0d integral saturations.",
               n_stops, n_flips, n_windup);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // watchdog
   initial begin : watchdog
      #(RUN_LIMIT_NS);
      $display("Regression FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
hdl/pidsr_pkg.sv
hdl/pidsr_if.sv
hdl/pidsr_front.sv
hdl/pidsr_queue.sv
hdl/pidsr_drive.sv
hdl/pid_stepper_speed_ramp_core.sv
dv/pid_stepper_speed_ramp_core_tb.sv
